@@ src/wrp_pkg.sv @@
// shared types and constants of the weighted random picker
package wrp_pkg;

	localparam int REQ_W    = 2;
	localparam int STATUS_W = 3;

	// request kinds
	typedef enum logic [REQ_W-1:0] {
		REQ_CLEAR  = 2'd0,
		REQ_ADD    = 2'd1,
		REQ_SELECT = 2'd2,
		REQ_REMOVE = 2'd3
	} req_t;

	// result status codes
	typedef enum logic [STATUS_W-1:0] {
		STAT_OK        = 3'd0,
		STAT_EMPTY     = 3'd1,
		STAT_DUP       = 3'd2,
		STAT_FULL      = 3'd3,
		STAT_BAD_INDEX = 3'd4
	} status_t;

	// sequencer states
	typedef enum logic [1:0] {
		S_IDLE = 2'd0,
		S_SCAN = 2'd1,
		S_FIN  = 2'd2
	} state_t;

	// shared arithmetic unit operations
	typedef enum logic {
		ALU_ADD = 1'b0,
		ALU_SUB = 1'b1
	} alu_op_t;

	// table memory strobes
	typedef struct packed {
		logic rd;
		logic wr;
	} mem_cmd_t;

endpackage

@@ src/weighted_random_picker_top.sv @@
// weighted random picker: stream ports, table memory, sequencer and result register
// clear and rejected requests skip the table walk and go straight to the result register;
// add and select walk up to all N entries and remove from index to the end, N the entry count, one table read a cycle
// select stops issuing reads once the entry under the draw is found
// throughput: one item at a time, a new request is taken only once the result is loaded
// reset: arst_n empties the table, clears the weight total and the last pick
module weighted_random_picker_top #(
	parameter int MAX_ENTRIES = 32,
	parameter int WEIGHT_BITS = 16,
	parameter int KEY_BITS    = 32
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	// entry_weight, entry_key, entry_index, random_value, avoid_valid, avoid_key
	input  logic [((2*KEY_BITS+2*WEIGHT_BITS+2*$clog2(MAX_ENTRIES)+1+7)/8)*8-1:0] s_tdata,
	// req_type
	input  logic [wrp_pkg::REQ_W-1:0] s_tuser,
	output logic m_tvalid,
	input  logic m_tready,
	// status, chosen_index, entry_count, weight_total
	output logic [((wrp_pkg::STATUS_W+2*$clog2(MAX_ENTRIES)+$clog2(MAX_ENTRIES+1)
		+WEIGHT_BITS+7)/8)*8-1:0] m_tdata
);
	import wrp_pkg::*;

	localparam int IDX_W  = $clog2(MAX_ENTRIES);
	localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
	localparam int TOT_W  = WEIGHT_BITS + IDX_W;
	localparam int DW     = KEY_BITS + WEIGHT_BITS;
	localparam int OUT_W  = STATUS_W + IDX_W + CNT_W + TOT_W;
	localparam int OUT_TW = ((OUT_W + 7) / 8) * 8;

	// input field offsets in s_tdata
	localparam int O_WEIGHT = 0;
	localparam int O_KEY    = O_WEIGHT + WEIGHT_BITS;
	localparam int O_INDEX  = O_KEY + KEY_BITS;
	localparam int O_RANDOM = O_INDEX + IDX_W;
	localparam int O_AVOIDV = O_RANDOM + TOT_W;
	localparam int O_AVOIDK = O_AVOIDV + 1;

	mem_cmd_t            mem_cmd;
	logic [IDX_W-1:0]    rd_addr, wr_addr;
	logic [DW-1:0]       wr_data, rd_data;
	alu_op_t             alu_op;
	logic [TOT_W-1:0]    alu_a, alu_res;
	logic [WEIGHT_BITS-1:0] alu_b;
	logic [KEY_BITS-1:0] alu_key_a, alu_key_b;
	logic                alu_borrow, alu_key_eq;
	logic                res_free, res_load;
	status_t             res_status;
	logic [IDX_W-1:0]    res_chosen;
	logic [CNT_W-1:0]    res_count;
	logic [TOT_W-1:0]    res_total;
	logic                m_tvalid_q;
	logic [OUT_W-1:0]    m_data_q;

	wrp_store #(
		.DEPTH (MAX_ENTRIES),
		.AW    (IDX_W),
		.DW    (DW)
	) u_store (
		.clk     (clk),
		.cmd     (mem_cmd),
		.rd_addr (rd_addr),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_data (rd_data)
	);

	wrp_alu #(
		.WEIGHT_BITS (WEIGHT_BITS),
		.KEY_BITS    (KEY_BITS),
		.TOT_W       (TOT_W)
	) u_alu (
		.op     (alu_op),
		.a      (alu_a),
		.b      (alu_b),
		.key_a  (alu_key_a),
		.key_b  (alu_key_b),
		.res    (alu_res),
		.borrow (alu_borrow),
		.key_eq (alu_key_eq)
	);

	wrp_ctrl #(
		.MAX_ENTRIES (MAX_ENTRIES),
		.WEIGHT_BITS (WEIGHT_BITS),
		.KEY_BITS    (KEY_BITS),
		.IDX_W       (IDX_W),
		.CNT_W       (CNT_W),
		.TOT_W       (TOT_W)
	) u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (s_tvalid),
		.in_ready       (s_tready),
		.in_req         (req_t'(s_tuser)),
		.in_weight      (s_tdata[O_WEIGHT +: WEIGHT_BITS]),
		.in_key         (s_tdata[O_KEY +: KEY_BITS]),
		.in_index       (s_tdata[O_INDEX +: IDX_W]),
		.in_random      (s_tdata[O_RANDOM +: TOT_W]),
		.in_avoid_valid (s_tdata[O_AVOIDV]),
		.in_avoid_key   (s_tdata[O_AVOIDK +: KEY_BITS]),
		.mem_cmd        (mem_cmd),
		.rd_addr        (rd_addr),
		.wr_addr        (wr_addr),
		.wr_data        (wr_data),
		.rd_data        (rd_data),
		.alu_op         (alu_op),
		.alu_a          (alu_a),
		.alu_b          (alu_b),
		.alu_key_a      (alu_key_a),
		.alu_key_b      (alu_key_b),
		.alu_res        (alu_res),
		.alu_borrow     (alu_borrow),
		.alu_key_eq     (alu_key_eq),
		.res_free       (res_free),
		.res_load       (res_load),
		.res_status     (res_status),
		.res_chosen     (res_chosen),
		.res_count      (res_count),
		.res_total      (res_total)
	);

	// result register, free when empty or being taken
	assign res_free = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			m_data_q <= {res_total, res_count, res_chosen, res_status};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = OUT_TW'(m_data_q);

endmodule

@@ src/wrp_store.sv @@
// entry table memory holding key and weight, one write and one registered read port
module wrp_store #(
	parameter int DEPTH = 32,
	parameter int AW    = 5,
	parameter int DW    = 48
) (
	input  logic                clk,
	input  wrp_pkg::mem_cmd_t   cmd,
	input  logic [AW-1:0]       rd_addr,
	input  logic [AW-1:0]       wr_addr,
	input  logic [DW-1:0]       wr_data,
	output logic [DW-1:0]       rd_data
);
	import wrp_pkg::*;

	logic [DW-1:0] mem [DEPTH];
	logic [DW-1:0] rd_data_q;

	// write port
	always_ff @(posedge clk) begin
		if (cmd.wr) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (cmd.rd) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

@@ src/wrp_alu.sv @@
// shared add/subtract unit with borrow and key equality compare
module wrp_alu #(
	parameter int WEIGHT_BITS = 16,
	parameter int KEY_BITS    = 32,
	parameter int TOT_W       = 21
) (
	input  wrp_pkg::alu_op_t       op,
	input  logic [TOT_W-1:0]       a,
	input  logic [WEIGHT_BITS-1:0] b,
	input  logic [KEY_BITS-1:0]    key_a,
	input  logic [KEY_BITS-1:0]    key_b,
	output logic [TOT_W-1:0]       res,
	output logic                   borrow,
	output logic                   key_eq
);
	import wrp_pkg::*;

	logic [TOT_W:0] a_ext;
	logic [TOT_W:0] b_ext;
	logic [TOT_W:0] sum;

	// one adder serves running total updates and the cumulative weight walk
	always_comb begin
		a_ext = {1'b0, a};
		b_ext = (TOT_W + 1)'(b);
		case (op)
			ALU_ADD: sum = a_ext + b_ext;
			ALU_SUB: sum = a_ext - b_ext;
			default: sum = a_ext - b_ext;
		endcase
	end

	assign res    = sum[TOT_W-1:0];
	assign borrow = sum[TOT_W];
	assign key_eq = (key_a == key_b);

endmodule

@@ src/wrp_ctrl.sv @@
// request sequencer: walks the table one entry per cycle and updates the picker state
module wrp_ctrl #(
	parameter int MAX_ENTRIES = 32,
	parameter int WEIGHT_BITS = 16,
	parameter int KEY_BITS    = 32,
	parameter int IDX_W       = 5,
	parameter int CNT_W       = 6,
	parameter int TOT_W       = 21
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// request side
	input  logic                            in_valid,
	output logic                            in_ready,
	input  wrp_pkg::req_t                   in_req,
	input  logic [WEIGHT_BITS-1:0]          in_weight,
	input  logic [KEY_BITS-1:0]             in_key,
	input  logic [IDX_W-1:0]                in_index,
	input  logic [TOT_W-1:0]                in_random,
	input  logic                            in_avoid_valid,
	input  logic [KEY_BITS-1:0]             in_avoid_key,
	// table memory
	output wrp_pkg::mem_cmd_t               mem_cmd,
	output logic [IDX_W-1:0]                rd_addr,
	output logic [IDX_W-1:0]                wr_addr,
	output logic [KEY_BITS+WEIGHT_BITS-1:0] wr_data,
	input  logic [KEY_BITS+WEIGHT_BITS-1:0] rd_data,
	// shared arithmetic unit
	output wrp_pkg::alu_op_t                alu_op,
	output logic [TOT_W-1:0]                alu_a,
	output logic [WEIGHT_BITS-1:0]          alu_b,
	output logic [KEY_BITS-1:0]             alu_key_a,
	output logic [KEY_BITS-1:0]             alu_key_b,
	input  logic [TOT_W-1:0]                alu_res,
	input  logic                            alu_borrow,
	input  logic                            alu_key_eq,
	// result side
	input  logic                            res_free,
	output logic                            res_load,
	output wrp_pkg::status_t                res_status,
	output logic [IDX_W-1:0]                res_chosen,
	output logic [CNT_W-1:0]                res_count,
	output logic [TOT_W-1:0]                res_total
);
	import wrp_pkg::*;

	state_t                  state_q, state_d;
	req_t                    req_q;
	status_t                 status_q;
	status_t                 acc_status;
	logic [WEIGHT_BITS-1:0]  weight_q;
	logic [KEY_BITS-1:0]     key_q;
	logic [IDX_W-1:0]        idx_q;
	logic [TOT_W-1:0]        r_q;
	logic                    avoid_q;
	logic [KEY_BITS-1:0]     avoid_key_q;
	logic                    dup_q;
	logic                    found_q;
	logic [IDX_W-1:0]        pick_q;
	logic [KEY_BITS-1:0]     pkey_q;
	logic [CNT_W-1:0]        rd_q;
	logic                    dv_q;
	logic [IDX_W-1:0]        di_q;
	logic [CNT_W-1:0]        count_q;
	logic [TOT_W-1:0]        total_q;
	logic [IDX_W-1:0]        lp_q;
	logic                    lpv_q;

	logic                    rd_en;
	logic [WEIGHT_BITS-1:0]  d_w;
	logic [KEY_BITS-1:0]     d_key;
	logic                    step1, step2;
	logic [IDX_W-1:0]        pick1, pick2;
	logic [CNT_W-1:0]        cnt_fin;
	logic [TOT_W-1:0]        tot_fin;
	logic [IDX_W-1:0]        lp_fin;
	logic                    lpv_fin;
	logic                    entry_ok;

	// next entry with wrap to the first one
	function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] i,
			input logic [CNT_W-1:0] n);
		logic [CNT_W-1:0] j;
		j = CNT_W'(i) + CNT_W'(1);
		return (j >= n) ? '0 : j[IDX_W-1:0];
	endfunction

	assign d_w   = rd_data[WEIGHT_BITS-1:0];
	assign d_key = rd_data[KEY_BITS+WEIGHT_BITS-1:WEIGHT_BITS];

	assign in_ready = (state_q == S_IDLE);
	assign rd_addr  = rd_q[IDX_W-1:0];
	assign entry_ok = (status_q == STAT_OK);

	// read issue: walk up to the fill count, stop early once a select hits
	assign rd_en = (state_q == S_SCAN) && (rd_q < count_q) &&
		!((req_q == REQ_SELECT) && found_q);

	// up-front checks that need no table walk
	always_comb begin
		acc_status = STAT_OK;
		case (in_req)
			REQ_ADD: begin
				if (count_q >= CNT_W'(MAX_ENTRIES)) acc_status = STAT_FULL;
			end
			REQ_SELECT: begin
				if (count_q == '0) acc_status = STAT_EMPTY;
			end
			REQ_REMOVE: begin
				if (CNT_W'(in_index) >= count_q) acc_status = STAT_BAD_INDEX;
			end
			default: acc_status = STAT_OK;
		endcase
	end

	// step past the last pick or the avoided key
	always_comb begin
		step1 = (count_q > CNT_W'(1)) &&
			((lpv_q && (lp_q == pick_q)) || (avoid_q && alu_key_eq));
		pick1 = step1 ? next_idx(pick_q, count_q) : pick_q;
		step2 = (count_q > CNT_W'(2)) && lpv_q && (lp_q == pick1);
		pick2 = step2 ? next_idx(pick1, count_q) : pick1;
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					if ((in_req != REQ_CLEAR) && (acc_status == STAT_OK)) state_d = S_SCAN;
					else state_d = S_FIN;
				end
			end
			S_SCAN: begin
				if (!rd_en && !dv_q) state_d = S_FIN;
			end
			S_FIN: begin
				if (res_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		mem_cmd     = '0;
		mem_cmd.rd  = rd_en;
		wr_addr     = count_q[IDX_W-1:0];
		wr_data     = {key_q, weight_q};
		alu_op      = ALU_SUB;
		alu_a       = (req_q == REQ_SELECT) ? r_q : total_q;
		alu_b       = d_w;
		alu_key_a   = d_key;
		alu_key_b   = key_q;
		res_load    = 1'b0;
		res_status  = status_q;
		res_chosen  = '0;
		cnt_fin     = count_q;
		tot_fin     = total_q;
		lp_fin      = lp_q;
		lpv_fin     = lpv_q;
		case (state_q)
			S_SCAN: begin
				// remove shifts each later entry down by one
				if (dv_q && (req_q == REQ_REMOVE) && (di_q != idx_q)) begin
					mem_cmd.wr = 1'b1;
					wr_addr    = di_q - IDX_W'(1);
					wr_data    = rd_data;
				end
			end
			S_FIN: begin
				alu_op    = ALU_ADD;
				alu_a     = total_q;
				alu_b     = weight_q;
				alu_key_a = pkey_q;
				alu_key_b = avoid_key_q;
				res_load  = res_free;
				case (req_q)
					REQ_CLEAR: begin
						cnt_fin = '0;
						tot_fin = '0;
						lpv_fin = 1'b0;
					end
					REQ_ADD: begin
						if (entry_ok && dup_q) begin
							res_status = STAT_DUP;
						end else if (entry_ok) begin
							mem_cmd.wr = res_free;
							cnt_fin    = count_q + CNT_W'(1);
							tot_fin    = alu_res;
						end
					end
					REQ_SELECT: begin
						if (entry_ok) begin
							lp_fin     = pick2;
							lpv_fin    = 1'b1;
							res_chosen = pick2;
						end
					end
					REQ_REMOVE: begin
						if (entry_ok) begin
							cnt_fin = count_q - CNT_W'(1);
							if (lpv_q && (lp_q >= idx_q)) begin
								if (lp_q == '0) lpv_fin = 1'b0;
								else lp_fin = lp_q - IDX_W'(1);
							end
						end
					end
					default: res_status = status_q;
				endcase
			end
			default: res_load = 1'b0;
		endcase
	end

	assign res_count = cnt_fin;
	assign res_total = tot_fin;

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			total_q <= '0;
			lp_q    <= '0;
			lpv_q   <= 1'b0;
			dv_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			dv_q    <= rd_en;
			if (res_load) begin
				count_q <= cnt_fin;
				total_q <= tot_fin;
				lp_q    <= lp_fin;
				lpv_q   <= lpv_fin;
			end else if ((state_q == S_SCAN) && dv_q && (req_q == REQ_REMOVE) &&
					(di_q == idx_q)) begin
				total_q <= alu_res;
			end
		end
	end

	// request fields and walk registers
	always_ff @(posedge clk) begin
		if ((state_q == S_IDLE) && in_valid) begin
			req_q       <= in_req;
			status_q    <= acc_status;
			weight_q    <= in_weight;
			key_q       <= in_key;
			idx_q       <= in_index;
			r_q         <= in_random;
			avoid_q     <= in_avoid_valid;
			avoid_key_q <= in_avoid_key;
			dup_q       <= 1'b0;
			found_q     <= 1'b0;
			rd_q        <= (in_req == REQ_REMOVE) ? CNT_W'(in_index) : '0;
		end else if (state_q == S_SCAN) begin
			di_q <= rd_q[IDX_W-1:0];
			if (rd_en) rd_q <= rd_q + CNT_W'(1);
			if (dv_q) begin
				case (req_q)
					REQ_ADD: begin
						if (alu_key_eq) dup_q <= 1'b1;
					end
					REQ_SELECT: begin
						// keep the latest entry so a miss clamps to the last one
						if (!found_q) begin
							pick_q <= di_q;
							pkey_q <= d_key;
							if (alu_borrow) found_q <= 1'b1;
							else r_q <= alu_res;
						end
					end
					default: dup_q <= dup_q;
				endcase
			end
		end
	end

endmodule
